[hw/rtl/bwcm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bwcm_pkg;

   // Fixed field and state widths.
   localparam int CODE_W      = 16;
   localparam int OUT_W       = 16;
   localparam int N_W         = 8;
   localparam int RATE_W      = 10;
   localparam int SC_W        = 25;
   localparam int SS_W        = 24;
   localparam int CHARGE_W    = 32;
   localparam int Q_FRAC_BITS = 16;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;

   // Shared divider operand widths. Every dividend that the back end forms stays below 2^47.
   localparam int DIVIDEND_W = 48;
   localparam int DIVISOR_W  = 30;

   // Scaling constants. Current offset 2 * 0.3531 A gives 706200 in units of 1e-6.
   localparam logic [21:0] K_CUR_GAIN    = 22'd2500000;
   localparam logic [19:0] K_CUR_OFFSET  = 20'd706200;
   localparam logic [8:0]  K_CUR_DEN     = 9'd264;
   localparam logic [12:0] K_SUP_GAIN    = 13'd5000;
   localparam logic [13:0] K_BAT_GAIN    = 14'd13000;
   localparam logic [19:0] K_CHARGE_DEN  = 20'd950400;

   // Power divides by 1000 as a shift by 3 and a multiplication by 2^36/125, rounded up.
   // The rounding error stays below one count for every product of two 16-bit values.
   localparam int          PWR_PRE_SHIFT   = 3;
   localparam int          PWR_RECIP_SHIFT = 36;
   localparam logic [29:0] K_PWR_RECIP     = 30'd549755814;

   localparam logic [N_W-1:0]    WINDOW_RESET = 8'd50;
   localparam logic [RATE_W-1:0] RATE_RESET   = 10'd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_SAMPLE_RATE   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                   en;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // One closed window, handed from the front end to the back end.
   typedef struct packed {
      logic [SC_W-1:0]   sc;
      logic [SS_W-1:0]   ss;
      logic [SS_W-1:0]   sb;
      logic [N_W-1:0]    n;
      logic [RATE_W-1:0] rate;
   } job_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

[hw/rtl/bwcm_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module bwcm_div
   import bwcm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // Restoring division, one quotient bit a cycle. The dividend shifts out at the top
   // of quo_ff while the quotient bits shift in at the bottom.
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

[hw/rtl/bwcm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bwcm_queue
   import bwcm_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire job_type push_data,
   output logic         full,
   output logic         pop_valid,
   output job_type      pop_data,
   input  wire logic    pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bwcm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bwcm_front
   import bwcm_pkg::*;
#(
   parameter int ADC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire csr_write_type     csr,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CODE_W-1:0] req_current_b_raw,
   input  wire logic [CODE_W-1:0] req_current_a_raw,
   input  wire logic [CODE_W-1:0] req_supply_raw,
   input  wire logic [CODE_W-1:0] req_battery_raw,
   output logic                   push_valid,
   output job_type                push_data,
   input  wire logic              push_full
);

   localparam logic [CODE_W-1:0] ADC_MASK = CODE_W'((17'd1 << ADC_BITS) - 17'd1);

   logic [N_W-1:0]    window_length_ff, window_length_in;
   logic [RATE_W-1:0] sample_rate_ff, sample_rate_in;
   logic [N_W-1:0]    scan_count_ff, scan_count_in;
   logic [SC_W-1:0]   sc_ff, sc_in;
   logic [SS_W-1:0]   ss_ff, ss_in;
   logic [SS_W-1:0]   sb_ff, sb_in;

   logic [N_W-1:0]    win;
   logic              closing;
   logic              accept;

   assign win     = (window_length_ff == '0) ? N_W'(1) : window_length_ff;
   assign closing = (scan_count_ff >= win);

   // Only a window-closing transaction needs room in the queue.
   assign req_stall  = closing && push_full;
   assign accept     = req_valid && !req_stall;
   assign push_valid = accept && closing;

   assign push_data.sc   = sc_ff;
   assign push_data.ss   = ss_ff;
   assign push_data.sb   = sb_ff;
   assign push_data.n    = scan_count_ff;
   assign push_data.rate = (sample_rate_ff == '0) ? RATE_W'(1) : sample_rate_ff;

   always_comb begin
      window_length_in = window_length_ff;
      sample_rate_in   = sample_rate_ff;
      if (csr.en) begin
         case (csr.index)
            CSR_WINDOW_LENGTH: window_length_in = csr.data[N_W-1:0];
            CSR_SAMPLE_RATE:   sample_rate_in   = csr.data[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      scan_count_in = scan_count_ff;
      sc_in         = sc_ff;
      ss_in         = ss_ff;
      sb_in         = sb_ff;
      if (accept) begin
         if (closing) begin
            scan_count_in = '0;
            sc_in         = '0;
            ss_in         = '0;
            sb_in         = '0;
         end else begin
            scan_count_in = scan_count_ff + N_W'(1);
            sc_in = sc_ff + SC_W'(req_current_b_raw & ADC_MASK)
                          + SC_W'(req_current_a_raw & ADC_MASK);
            ss_in = ss_ff + SS_W'(req_supply_raw & ADC_MASK);
            sb_in = sb_ff + SS_W'(req_battery_raw & ADC_MASK);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
         sample_rate_ff   <= RATE_RESET;
         scan_count_ff    <= '0;
         sc_ff            <= '0;
         ss_ff            <= '0;
         sb_ff            <= '0;
      end else begin
         window_length_ff <= window_length_in;
         sample_rate_ff   <= sample_rate_in;
         scan_count_ff    <= scan_count_in;
         sc_ff            <= sc_in;
         ss_ff            <= ss_in;
         sb_ff            <= sb_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bwcm_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bwcm_back
   import bwcm_pkg::*;
#(
   parameter int ADC_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_valid,
   input  wire job_type      q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [OUT_W-1:0]  rsp_consumption_mah,
   output logic [OUT_W-1:0]  rsp_current_ma,
   output logic [OUT_W-1:0]  rsp_power_mw,
   output logic [OUT_W-1:0]  rsp_supply_mv,
   output logic [OUT_W-1:0]  rsp_battery_mv
);

   localparam int NCP_W     = SC_W + 22;
   localparam int NCN_W     = N_W + 20;
   localparam int NC_W      = NCP_W + 2;
   localparam int SUPP_W    = SS_W + 13;
   localparam int BATP_W    = SS_W + 14;
   localparam int DCUR_W    = N_W + 9;
   localparam int PWRP_W    = 2 * OUT_W;
   localparam int PWRS_W    = PWRP_W - PWR_PRE_SHIFT;
   localparam int PWRM_W    = PWRS_W + $bits(K_PWR_RECIP);
   localparam int EXT_W     = DIVIDEND_W + 1;
   localparam int INC_SHIFT = Q_FRAC_BITS - ADC_BITS;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_MUL   = 8'b00000010,
      ST_NC    = 8'b00000100,
      ST_LOAD  = 8'b00001000,
      ST_DIV   = 8'b00010000,
      ST_PWR   = 8'b00100000,
      ST_SCALE = 8'b01000000,
      ST_OUT   = 8'b10000000
   } back_state_type;

   typedef enum logic [2:0] {
      OP_INC = 3'd0,
      OP_CUR = 3'd1,
      OP_SUP = 3'd2,
      OP_BAT = 3'd3
   } div_op_type;

   back_state_type state_ff, state_in;
   div_op_type     op_ff, op_in;

   job_type              job_ff;
   logic [NCP_W-1:0]     ncp_ff;
   logic [NCN_W-1:0]     ncn_ff;
   logic [NC_W-1:0]      nc_ff;
   logic [DIVISOR_W-1:0] den_inc_ff;
   logic [DCUR_W-1:0]    den_cur_ff;
   logic [SUPP_W-1:0]    sup_prod_ff;
   logic [BATP_W-1:0]    bat_prod_ff;
   logic [PWRP_W-1:0]    pwr_prod_ff;
   logic [OUT_W-1:0]     cur_ff;
   logic [OUT_W-1:0]     sup_ff;
   logic [OUT_W-1:0]     bat_ff;
   logic [OUT_W-1:0]     pwr_ff;
   logic [CHARGE_W-1:0]  charge_ff, charge_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     rsp_mah_ff;
   logic [OUT_W-1:0]     rsp_cur_ff;
   logic [OUT_W-1:0]     rsp_pwr_ff;
   logic [OUT_W-1:0]     rsp_sup_ff;
   logic [OUT_W-1:0]     rsp_bat_ff;

   div_req_type          div_req;
   div_rsp_type          div_rsp;

   logic                 nc_neg;
   logic [NC_W-1:0]      nc_mag;
   logic [DIVIDEND_W-1:0] dividend_sel;
   logic [DIVISOR_W-1:0] divisor_sel;
   logic                 div_done;
   logic                 load_out;
   logic [EXT_W-1:0]     charge_ext;
   logic [EXT_W-1:0]     step_up;
   logic [EXT_W-1:0]     step_down;
   logic [PWRM_W-1:0]    pwr_scaled;

   function automatic logic [OUT_W-1:0] sat16(input logic [DIVIDEND_W-1:0] q);
      logic [OUT_W-1:0] r;
      r = (|q[DIVIDEND_W-1:OUT_W]) ? '1 : q[OUT_W-1:0];
      return r;
   endfunction

   bwcm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign nc_neg   = nc_ff[NC_W-1];
   assign nc_mag   = nc_neg ? (~nc_ff + NC_W'(1)) : nc_ff;
   assign div_done = (state_ff == ST_DIV) && div_rsp.done;
   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign pwr_scaled = PWRM_W'(pwr_prod_ff >> PWR_PRE_SHIFT) * PWRM_W'(K_PWR_RECIP);

   // Averages divide by the window's scan count; the full-scale factor is a plain shift.
   always_comb begin
      case (op_ff)
         OP_INC: begin
            dividend_sel = DIVIDEND_W'(nc_mag << INC_SHIFT);
            divisor_sel  = den_inc_ff;
         end
         OP_CUR: begin
            dividend_sel = nc_neg ? '0 : DIVIDEND_W'(nc_ff >> ADC_BITS);
            divisor_sel  = DIVISOR_W'(den_cur_ff);
         end
         OP_SUP: begin
            dividend_sel = DIVIDEND_W'(sup_prod_ff >> ADC_BITS);
            divisor_sel  = DIVISOR_W'(job_ff.n);
         end
         OP_BAT: begin
            dividend_sel = DIVIDEND_W'(bat_prod_ff >> ADC_BITS);
            divisor_sel  = DIVISOR_W'(job_ff.n);
         end
         default: begin
            dividend_sel = '0;
            divisor_sel  = DIVISOR_W'(1);
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      q_pop           = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = dividend_sel;
      div_req.divisor  = divisor_sel;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_NC;
         ST_NC: begin
            op_in    = OP_INC;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               case (op_ff)
                  OP_INC: begin
                     op_in    = OP_CUR;
                     state_in = ST_LOAD;
                  end
                  OP_CUR: begin
                     op_in    = OP_SUP;
                     state_in = ST_LOAD;
                  end
                  OP_SUP: begin
                     op_in    = OP_BAT;
                     state_in = ST_LOAD;
                  end
                  OP_BAT: state_in = ST_PWR;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PWR: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The charge step is floored, so a negative step with a remainder takes one more count.
   always_comb begin
      charge_ext = EXT_W'(charge_ff);
      step_up    = charge_ext + EXT_W'(div_rsp.quotient);
      step_down  = EXT_W'(div_rsp.quotient) + EXT_W'(|div_rsp.remainder);
      if (nc_neg) begin
         charge_in = (charge_ext >= step_down) ? CHARGE_W'(charge_ext - step_down) : '0;
      end else begin
         charge_in = (|step_up[EXT_W-1:CHARGE_W]) ? '1 : step_up[CHARGE_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid) begin
         job_ff <= q_data;
      end
      if (state_ff == ST_MUL) begin
         ncp_ff     <= NCP_W'(job_ff.sc) * NCP_W'(K_CUR_GAIN);
         ncn_ff     <= NCN_W'(job_ff.n) * NCN_W'(K_CUR_OFFSET);
         den_inc_ff <= DIVISOR_W'(job_ff.rate) * DIVISOR_W'(K_CHARGE_DEN);
      end
      if (state_ff == ST_NC) begin
         nc_ff       <= NC_W'(ncp_ff) - (NC_W'(ncn_ff) << ADC_BITS);
         sup_prod_ff <= SUPP_W'(job_ff.ss) * SUPP_W'(K_SUP_GAIN);
         bat_prod_ff <= BATP_W'(job_ff.sb) * BATP_W'(K_BAT_GAIN);
         den_cur_ff  <= DCUR_W'(job_ff.n) * DCUR_W'(K_CUR_DEN);
      end
      if (div_done) begin
         case (op_ff)
            OP_CUR:  cur_ff <= sat16(div_rsp.quotient);
            OP_SUP:  sup_ff <= sat16(div_rsp.quotient);
            OP_BAT:  bat_ff <= sat16(div_rsp.quotient);
            default: ;
         endcase
      end
      if (state_ff == ST_PWR) begin
         pwr_prod_ff <= PWRP_W'(cur_ff) * PWRP_W'(bat_ff);
      end
      if (state_ff == ST_SCALE) begin
         pwr_ff <= sat16(DIVIDEND_W'(pwr_scaled >> PWR_RECIP_SHIFT));
      end
      if (load_out) begin
         rsp_mah_ff <= charge_ff[CHARGE_W-1:CHARGE_W-OUT_W];
         rsp_cur_ff <= cur_ff;
         rsp_pwr_ff <= pwr_ff;
         rsp_sup_ff <= sup_ff;
         rsp_bat_ff <= bat_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_INC;
         charge_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         if (div_done && op_ff == OP_INC) begin
            charge_ff <= charge_in;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_consumption_mah = rsp_mah_ff;
   assign rsp_current_ma      = rsp_cur_ff;
   assign rsp_power_mw        = rsp_pwr_ff;
   assign rsp_supply_mv       = rsp_sup_ff;
   assign rsp_battery_mv      = rsp_bat_ff;

endmodule

`default_nettype wire

[hw/rtl/battery_window_coulomb_monitor.sv]
// Battery window monitor with coulomb counter. Each request transaction carries one scan of
// two current codes, a supply code and a battery code. Scans are summed until the open window
// holds window_length of them; the next scan closes the window, its codes are dropped, and it
// produces one response transaction with the window averages (mA, mV, mW) and the running
// charge in mAh, each saturated to 16 bits. A scan that only accumulates is taken back to
// back. A closed window is queued and worked out by the back end with the shared 48-step
// restoring divider, which runs four divisions in turn, one quotient bit per cycle; power
// is then formed as a product and scaled by a constant reciprocal.
// While the queue is full, only a window-closing scan is stalled.
// Registers are window_length (index 0) and sample_rate_hz (index 1); a value of zero in
// either acts as one.
`timescale 1ns / 1ps
`default_nettype none

module battery_window_coulomb_monitor
   import bwcm_pkg::*;
#(
   parameter int ADC_BITS    = 16,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [CODE_W-1:0]      req_current_b_raw,
   input  wire logic [CODE_W-1:0]      req_current_a_raw,
   input  wire logic [CODE_W-1:0]      req_supply_raw,
   input  wire logic [CODE_W-1:0]      req_battery_raw,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [OUT_W-1:0]            rsp_consumption_mah,
   output logic [OUT_W-1:0]            rsp_current_ma,
   output logic [OUT_W-1:0]            rsp_power_mw,
   output logic [OUT_W-1:0]            rsp_supply_mv,
   output logic [OUT_W-1:0]            rsp_battery_mv
);

   csr_write_type csr;
   logic          push_valid;
   job_type       push_data;
   logic          q_full;
   logic          q_valid;
   job_type       q_data;
   logic          q_pop;

   assign csr.en    = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.data  = csr_wdata;

   bwcm_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr               (csr),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_current_b_raw (req_current_b_raw),
      .req_current_a_raw (req_current_a_raw),
      .req_supply_raw    (req_supply_raw),
      .req_battery_raw   (req_battery_raw),
      .push_valid        (push_valid),
      .push_data         (push_data),
      .push_full         (q_full)
   );

   bwcm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_data   (q_data),
      .pop        (q_pop)
   );

   bwcm_back #(
      .ADC_BITS (ADC_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_data              (q_data),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_consumption_mah (rsp_consumption_mah),
      .rsp_current_ma      (rsp_current_ma),
      .rsp_power_mw        (rsp_power_mw),
      .rsp_supply_mv       (rsp_supply_mv),
      .rsp_battery_mv      (rsp_battery_mv)
   );

   // A closed window must never be pushed into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("window pushed into a full queue");

   // The request side is held off only for lack of queue space.
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> q_full)
      else $error("request stalled while the queue has room");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("back end popped an empty queue");

   // Power is derived from the current average, so zero current must give zero power.
   a_power_follows_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_current_ma == '0) |-> (rsp_power_mw == '0))
      else $error("non-zero power reported with zero current");

endmodule

`default_nettype wire

[tb/tb_battery_window_coulomb_monitor.sv]
`timescale 1ns / 1ps

module tb_battery_window_coulomb_monitor;
   import bwcm_pkg::*;

   localparam int    RANDOM_SCANS   = 1050;
   localparam int    LONG_PHASE     = 3;
   localparam int    SETTLE_CYCLES  = 300;
   localparam int    WATCHDOG_LIMIT = 4000;

   localparam longint FULL_SCALE    = 65536;
   localparam longint Q16_ONE       = 65536;
   localparam longint CUR_GAIN      = 2500000;
   localparam longint CUR_OFFSET    = 706200;
   localparam longint CUR_DEN       = 264;
   localparam longint SUP_MV_GAIN   = 5000;
   localparam longint BAT_MV_GAIN   = 13000;
   localparam longint MW_DEN        = 1000;
   localparam longint SECS_PER_HOUR = 3600;

   typedef struct packed {
      logic [CODE_W-1:0] cur_b;
      logic [CODE_W-1:0] cur_a;
      logic [CODE_W-1:0] supply;
      logic [CODE_W-1:0] battery;
   } scan_t;

   typedef struct packed {
      logic [OUT_W-1:0] mah;
      logic [OUT_W-1:0] cur_ma;
      logic [OUT_W-1:0] pwr_mw;
      logic [OUT_W-1:0] sup_mv;
      logic [OUT_W-1:0] bat_mv;
   } reading_t;

   typedef enum logic {ROW_SCAN, ROW_WRITE} row_kind_e;
   typedef enum int {CODES_ANY, CODES_RAIL, CODES_DRAIN, CODES_IDLE} code_style_e;

   typedef struct packed {
      row_kind_e             kind;
      csr_index_type         idx;
      logic [CSR_DATA_W-1:0] data;
      scan_t                 codes;
      logic                  typed;
      reading_t              want;
   } step_t;

   // Rows with a typed reading close a single-scan window of all-zero or all-full-scale codes.
   localparam step_t PLAN [22] = '{
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      '{ROW_WRITE, CSR_WINDOW_LENGTH, 10'd1,   '0, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h1234, 16'h1234, 16'h1234, 16'h1234}, 1'b1,
        {16'd0, 16'd0, 16'd0, 16'd0, 16'd0}},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h8001, 16'h8001, 16'h8001, 16'h8001}, 1'b1,
        {16'd0, 16'd16264, 16'd65535, 16'd4999, 16'd12999}},
      '{ROW_WRITE, CSR_WINDOW_LENGTH, 10'd0,   '0, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'hA5A5, 16'h5A5A, 16'hA5A5, 16'h5A5A}, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h5A5A, 16'hA5A5, 16'h5A5A, 16'hA5A5}, 1'b0, '0},
      '{ROW_WRITE, CSR_SAMPLE_RATE,   10'd0,   '0, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
      '{ROW_WRITE, CSR_SAMPLE_RATE,   10'd1000, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_WINDOW_LENGTH, 10'h103, '0, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h2428, 16'h2428, 16'h8000, 16'h8000}, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h2429, 16'h2428, 16'hFFFF, 16'h0000}, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h0001, 16'h0002, 16'h0004, 16'h0008}, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE}, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h8000, 16'h0001, 16'hFFFE, 16'h7FFF}, 1'b0, '0},
      '{ROW_WRITE, CSR_SAMPLE_RATE,   10'h3FF, '0, 1'b0, '0},
      '{ROW_WRITE, CSR_WINDOW_LENGTH, 10'd1,   '0, 1'b0, '0},
      '{ROW_SCAN,  CSR_WINDOW_LENGTH, 10'd0,   {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0}
   };

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic [CODE_W-1:0]      req_current_b_raw = '0;
   logic [CODE_W-1:0]      req_current_a_raw = '0;
   logic [CODE_W-1:0]      req_supply_raw    = '0;
   logic [CODE_W-1:0]      req_battery_raw   = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic [OUT_W-1:0]       rsp_consumption_mah;
   logic [OUT_W-1:0]       rsp_current_ma;
   logic [OUT_W-1:0]       rsp_power_mw;
   logic [OUT_W-1:0]       rsp_supply_mv;
   logic [OUT_W-1:0]       rsp_battery_mv;

   // Mirror of the monitor's registers and window state.
   logic [N_W-1:0]      win_cfg     = 8'd50;
   logic [RATE_W-1:0]   rate_cfg    = 10'd100;
   logic [N_W-1:0]      open_scans  = '0;
   logic [SC_W-1:0]     cur_total   = '0;
   logic [SS_W-1:0]     sup_total   = '0;
   logic [SS_W-1:0]     bat_total   = '0;
   logic [CHARGE_W-1:0] charge_q16  = '0;

   reading_t pending_readings [$];
   int       fault_count    = 0;
   int       scans_sent     = 0;
   int       readings_seen  = 0;
   int       writes_done    = 0;
   int       quiet_cycles   = 0;
   int       stall_left     = 0;
   bit       calm           = 1'b0;

   battery_window_coulomb_monitor DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_current_b_raw   (req_current_b_raw),
      .req_current_a_raw   (req_current_a_raw),
      .req_supply_raw      (req_supply_raw),
      .req_battery_raw     (req_battery_raw),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_consumption_mah (rsp_consumption_mah),
      .rsp_current_ma      (rsp_current_ma),
      .rsp_power_mw        (rsp_power_mw),
      .rsp_supply_mv       (rsp_supply_mv),
      .rsp_battery_mv      (rsp_battery_mv)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint floor_div(input longint num, input longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      return q;
   endfunction

   function automatic logic [OUT_W-1:0] clamp16(input longint v);
      if (v < 0) return '0;
      if (v > 65535) return 16'hFFFF;
      return v[OUT_W-1:0];
   endfunction

   // Adds one scan to the open window, or closes the window and works out its reading.
   function automatic bit fold_scan(input scan_t s, output reading_t r);
      longint n, nc, inc, acc, win, rate;
      win  = (win_cfg == 0) ? 1 : longint'(win_cfg);
      rate = (rate_cfg == 0) ? 1 : longint'(rate_cfg);
      r = '0;
      if (longint'(open_scans) < win) begin
         cur_total  += SC_W'(s.cur_b) + SC_W'(s.cur_a);
         sup_total  += SS_W'(s.supply);
         bat_total  += SS_W'(s.battery);
         open_scans += N_W'(1);
         return 1'b0;
      end
      n   = longint'(open_scans);
      nc  = longint'(cur_total) * CUR_GAIN - CUR_OFFSET * n * FULL_SCALE;
      inc = floor_div(nc * Q16_ONE, CUR_DEN * FULL_SCALE * rate * SECS_PER_HOUR);
      acc = longint'(charge_q16) + inc;
      if (acc < 0) acc = 0;
      if (acc > 64'sh0_FFFF_FFFF) acc = 64'sh0_FFFF_FFFF;
      charge_q16 = acc[CHARGE_W-1:0];
      r.mah    = charge_q16[CHARGE_W-1:Q_FRAC_BITS];
      r.cur_ma = clamp16(floor_div(nc, CUR_DEN * FULL_SCALE * n));
      r.sup_mv = clamp16(floor_div(longint'(sup_total) * SUP_MV_GAIN, FULL_SCALE * n));
      r.bat_mv = clamp16(floor_div(longint'(bat_total) * BAT_MV_GAIN, FULL_SCALE * n));
      r.pwr_mw = clamp16(floor_div(longint'(r.cur_ma) * longint'(r.bat_mv), MW_DEN));
      open_scans = '0;
      cur_total  = '0;
      sup_total  = '0;
      bat_total  = '0;
      return 1'b1;
   endfunction

   // Mostly no gap, sometimes a short one, now and then a long one; none at all while calm.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic scan_t random_scan(input code_style_e style);
      scan_t s;
      int    k;
      s = {$urandom, $urandom};
      case (style)
         CODES_RAIL: begin
            for (k = 0; k < 4; k++) begin
               case ($urandom_range(0, 2))
                  0: s[k*CODE_W +: CODE_W] = '0;
                  1: s[k*CODE_W +: CODE_W] = '1;
                  default: ;
               endcase
            end
         end
         // Current codes below the sensor offset give a negative window current.
         CODES_DRAIN: begin
            s.cur_a = CODE_W'($urandom_range(0, 9256));
            s.cur_b = CODE_W'($urandom_range(0, 9256));
         end
         CODES_IDLE: begin
            s.cur_a = CODE_W'($urandom_range(9100, 9400));
            s.cur_b = CODE_W'($urandom_range(9100, 9400));
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic send_scan(input scan_t s, input bit typed, input reading_t want);
      int       gap;
      reading_t predicted;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_current_b_raw <= s.cur_b;
      req_current_a_raw <= s.cur_a;
      req_supply_raw    <= s.supply;
      req_battery_raw   <= s.battery;
      do @(posedge clock); while (req_stall);
      scans_sent++;
      if (fold_scan(s, predicted)) pending_readings.push_back(typed ? want : predicted);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_WINDOW_LENGTH) win_cfg = value[N_W-1:0];
      else rate_cfg = value[RATE_W-1:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
      writes_done++;
   endtask

   // Waits until every reading has come back and the back end has had time to go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      reading_t got, want;
      got = {rsp_consumption_mah, rsp_current_ma, rsp_power_mw, rsp_supply_mv, rsp_battery_mv};
      if (!reset && rsp_valid && !rsp_stall) begin
         readings_seen++;
         if (pending_readings.size() == 0) begin
            if (fault_count < 10)
               $display("Unexpected reading %0d: mah=%0d mA=%0d mW=%0d supply=%0d battery=%0d",
                        readings_seen, got.mah, got.cur_ma, got.pwr_mw, got.sup_mv, got.bat_mv);
            fault_count++;
         end else begin
            want = pending_readings.pop_front();
            if (got !== want) begin
               if (fault_count < 10) begin
                  $display("Reading %0d mismatch at %0t", readings_seen, $realtime);
                  $display("  expected mah=%0d mA=%0d mW=%0d supply=%0d battery=%0d",
                           want.mah, want.cur_ma, want.pwr_mw, want.sup_mv, want.bat_mv);
                  $display("  actual   mah=%0d mA=%0d mW=%0d supply=%0d battery=%0d",
                           got.mah, got.cur_ma, got.pwr_mw, got.sup_mv, got.bat_mv);
               end
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("No transaction for %0d cycles, %0d readings still awaited",
                  WATCHDOG_LIMIT, pending_readings.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int                    scans_left;
      int                    phase_no;
      int                    burst;
      code_style_e           style;
      logic [CSR_DATA_W-1:0] value;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_WRITE) begin
            settle();
            write_reg(PLAN[i].idx, PLAN[i].data);
         end else begin
            send_scan(PLAN[i].codes, PLAN[i].typed, PLAN[i].want);
         end
      end

      // Random phases; a phase may end mid-window, so later settings also shorten windows.
      scans_left = RANDOM_SCANS;
      phase_no   = 0;
      while (scans_left > 0) begin
         if (phase_no != 0) begin
            settle();
            if (phase_no == LONG_PHASE) begin
               write_reg(CSR_WINDOW_LENGTH, 10'd255);
            end else if ($urandom_range(0, 3) != 0) begin
               case ($urandom_range(0, 9))
                  0: value = '0;
                  1: value = CSR_DATA_W'($urandom_range(9, 40));
                  default: value = CSR_DATA_W'($urandom_range(1, 8));
               endcase
               value[CSR_DATA_W-1:N_W] = (CSR_DATA_W-N_W)'($urandom_range(0, 3));
               write_reg(CSR_WINDOW_LENGTH, value);
            end
            if ($urandom_range(0, 2) != 0) begin
               case ($urandom_range(0, 7))
                  0: value = 10'd0;
                  1: value = 10'd1;
                  2: value = 10'd1000;
                  3: value = 10'd1023;
                  default: value = CSR_DATA_W'($urandom_range(0, 1023));
               endcase
               write_reg(CSR_SAMPLE_RATE, value);
            end
         end
         calm  = ($urandom_range(0, 4) == 0);
         style = code_style_e'($urandom_range(0, 3));
         burst = (phase_no == LONG_PHASE) ? 300 : $urandom_range(6, 40);
         if (burst > scans_left) burst = scans_left;
         repeat (burst)
            send_scan(($urandom_range(0, 4) == 0) ? random_scan(CODES_ANY) : random_scan(style),
                      1'b0, '0);
         scans_left -= burst;
         phase_no++;
      end

      settle();
      $display("Sent %0d scans over %0d phases with %0d register writes,", scans_sent,
               phase_no, writes_done);
      $display("window lengths 0 to 255, sample rates 0 to 1023; %0d readings checked.",
               readings_seen);
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
